>>> sv/spcm_pkg.sv
package spcm_pkg;

  localparam int LIST_DEPTH_DEF = 32;
  localparam int VERTEX_W = 32;
  localparam int KEY_W = 2 * VERTEX_W;
  localparam int CNT_W = 32;
  localparam int ENTRY_W = KEY_W + CNT_W;
  localparam int MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MERGE = 2'd2;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic begin_merge;
    logic step;
    logic clear;
  } spcm_cmd_t;

  typedef struct packed {
    logic more;
    logic step_last;
  } spcm_status_t;

endpackage

>>> sv/spcm_ctrl.sv
module spcm_ctrl import spcm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MODE_W-1:0] mode,
  input  spcm_status_t      status,
  output spcm_cmd_t         cmd,
  output logic              busy
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_MERGE = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (mode)
            MODE_LOAD_A: cmd.load_a = 1'b1;
            MODE_LOAD_B: cmd.load_b = 1'b1;
            MODE_MERGE: begin
              cmd.begin_merge = 1'b1;
              state_nxt = ST_MERGE;
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        cmd.step = status.more;
        if (!status.more || status.step_last) begin
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> sv/spcm_datapath.sv
module spcm_datapath import spcm_pkg::*; #(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  spcm_cmd_t           cmd,
  input  logic [VERTEX_W-1:0] in_src_vertex,
  input  logic [VERTEX_W-1:0] in_dst_vertex,
  input  logic [CNT_W-1:0]    in_count,
  output spcm_status_t        status,
  output logic                out_valid,
  output logic [VERTEX_W-1:0] out_src,
  output logic [VERTEX_W-1:0] out_dst,
  output logic [CNT_W-1:0]    out_count,
  output logic                out_overflow,
  output logic                out_last
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic [ENTRY_W-1:0] mem_a [LIST_DEPTH];
  logic [ENTRY_W-1:0] mem_b [LIST_DEPTH];

  logic [ENTRY_W-1:0] rd_a_r;
  logic [ENTRY_W-1:0] rd_b_r;
  logic [CW-1:0] fill_a_r;
  logic [CW-1:0] fill_b_r;
  logic [CW-1:0] i_r;
  logic [CW-1:0] i_nxt;
  logic [CW-1:0] j_r;
  logic [CW-1:0] j_nxt;
  logic dropped_r;
  logic out_valid_r;
  logic [VERTEX_W-1:0] out_src_r;
  logic [VERTEX_W-1:0] out_dst_r;
  logic [CNT_W-1:0] out_count_r;
  logic out_overflow_r;
  logic out_last_r;

  logic [ENTRY_W-1:0] wr_entry;
  logic a_has;
  logic b_has;
  logic [KEY_W-1:0] key_a;
  logic [KEY_W-1:0] key_b;
  logic [CNT_W-1:0] cnt_a;
  logic [CNT_W-1:0] cnt_b;
  logic [CNT_W:0] sum_wide;
  logic [CNT_W-1:0] sum_sat;
  logic take_a;
  logic take_b;
  logic take_both;
  logic adv_a;
  logic adv_b;
  logic [CW-1:0] i_adv;
  logic [CW-1:0] j_adv;
  logic [KEY_W-1:0] sel_key;
  logic [CNT_W-1:0] sel_cnt;
  logic a_room;
  logic b_room;

  assign wr_entry = {in_src_vertex, in_dst_vertex, in_count};
  assign a_room = (fill_a_r < CW'(LIST_DEPTH));
  assign b_room = (fill_b_r < CW'(LIST_DEPTH));

  assign key_a = rd_a_r[ENTRY_W-1:CNT_W];
  assign key_b = rd_b_r[ENTRY_W-1:CNT_W];
  assign cnt_a = rd_a_r[CNT_W-1:0];
  assign cnt_b = rd_b_r[CNT_W-1:0];
  assign a_has = (i_r < fill_a_r);
  assign b_has = (j_r < fill_b_r);

  assign sum_wide = {1'b0, cnt_a} + {1'b0, cnt_b};
  assign sum_sat = sum_wide[CNT_W] ? {CNT_W{1'b1}} : sum_wide[CNT_W-1:0];

  assign take_both = a_has && b_has && (key_a == key_b);
  assign take_a = a_has && (!b_has || (key_a < key_b));
  assign take_b = b_has && (!a_has || (key_b < key_a));
  assign adv_a = take_a || take_both;
  assign adv_b = take_b || take_both;
  assign i_adv = adv_a ? (i_r + CW'(1)) : i_r;
  assign j_adv = adv_b ? (j_r + CW'(1)) : j_r;

  assign sel_key = take_b ? key_b : key_a;
  assign sel_cnt = take_both ? sum_sat : (take_b ? cnt_b : cnt_a);

  assign status.more = a_has || b_has;
  assign status.step_last = (i_adv >= fill_a_r) && (j_adv >= fill_b_r);

  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    if (cmd.begin_merge) begin
      i_nxt = '0;
      j_nxt = '0;
    end else if (cmd.step) begin
      i_nxt = i_adv;
      j_nxt = j_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_a && a_room) begin
      mem_a[fill_a_r[AW-1:0]] <= wr_entry;
    end
    if (cmd.load_b && b_room) begin
      mem_b[fill_b_r[AW-1:0]] <= wr_entry;
    end
    rd_a_r <= mem_a[i_nxt[AW-1:0]];
    rd_b_r <= mem_b[j_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    out_src_r <= sel_key[KEY_W-1:VERTEX_W];
    out_dst_r <= sel_key[VERTEX_W-1:0];
    out_count_r <= sel_cnt;
    out_overflow_r <= dropped_r;
    out_last_r <= cmd.step && status.step_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_a_r <= '0;
      fill_b_r <= '0;
      dropped_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.step;
      if (cmd.clear) begin
        fill_a_r <= '0;
        fill_b_r <= '0;
        dropped_r <= 1'b0;
      end else begin
        if (cmd.load_a) begin
          if (a_room) begin
            fill_a_r <= fill_a_r + CW'(1);
          end else begin
            dropped_r <= 1'b1;
          end
        end
        if (cmd.load_b) begin
          if (b_room) begin
            fill_b_r <= fill_b_r + CW'(1);
          end else begin
            dropped_r <= 1'b1;
          end
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_src = out_src_r;
  assign out_dst = out_dst_r;
  assign out_count = out_count_r;
  assign out_overflow = out_overflow_r;
  assign out_last = out_last_r && out_valid_r;

endmodule

>>> sv/sorted_pair_count_merge_top.sv
// Loads into either list can be issued back to back. A merge fetches the list heads
// in the cycle it is accepted and then holds busy while it selects the merged entries,
// since each list memory has a single registered read port that advances by at most
// one entry per cycle; a merge of empty lists raises busy but emits nothing. Each
// result transaction appears for exactly one cycle on out_valid, in the cycle after
// it is selected, so the last one shows in the cycle in which busy falls. The
// receiver cannot stall it, so it must take every strobe. Lists
// hold LIST_DEPTH entries; further loads are dropped and flagged on out_overflow of
// every entry of the next merge, after which both lists are empty.
module sorted_pair_count_merge_top import spcm_pkg::*; #(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [VERTEX_W-1:0] in_src_vertex,
  input  logic [VERTEX_W-1:0] in_dst_vertex,
  input  logic [CNT_W-1:0]    in_count,
  output logic                out_valid,
  output logic [VERTEX_W-1:0] out_src,
  output logic [VERTEX_W-1:0] out_dst,
  output logic [CNT_W-1:0]    out_count,
  output logic                out_overflow,
  output logic                out_last
);

  spcm_cmd_t cmd;
  spcm_status_t status;

  spcm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .mode   (in_mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  spcm_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_src_vertex (in_src_vertex),
    .in_dst_vertex (in_dst_vertex),
    .in_count      (in_count),
    .status        (status),
    .out_valid     (out_valid),
    .out_src       (out_src),
    .out_dst       (out_dst),
    .out_count     (out_count),
    .out_overflow  (out_overflow),
    .out_last      (out_last)
  );

  a_result_in_merge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe outside a merge");

  a_no_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result strobe after the last entry");

  a_merge_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_mode == MODE_MERGE) |=> busy)
    else $error("merge transaction did not raise busy");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && ((in_mode == MODE_LOAD_A) || (in_mode == MODE_LOAD_B)) |=> !busy)
    else $error("load transaction raised busy");

endmodule

>>> tb/sv/tb_sorted_pair_count_merge_top.sv
`timescale 1ns / 1ps

module tb_sorted_pair_count_merge_top import spcm_pkg::*;;

  localparam int DEPTH = LIST_DEPTH_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int TARGET_ITEMS = 320;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [VERTEX_W-1:0] src;
    logic [VERTEX_W-1:0] dst;
    logic [CNT_W-1:0]    cnt;
    logic                ovf;
    logic                is_last;
  } merged_entry_t;

  class pair_count_board;
    logic [KEY_W-1:0] keys_a[$];
    logic [KEY_W-1:0] keys_b[$];
    logic [CNT_W-1:0] cnts_a[$];
    logic [CNT_W-1:0] cnts_b[$];
    bit               dropped;
    merged_entry_t    pending[$];
    int               depth;
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      merges;
    int unsigned      dropped_loads;
    int unsigned      saturated;

    function new(int list_depth);
      depth = list_depth;
    endfunction

    function void push_entry(logic [KEY_W-1:0] key, logic [CNT_W-1:0] cnt);
      merged_entry_t e;
      e.src = key[KEY_W-1:VERTEX_W];
      e.dst = key[VERTEX_W-1:0];
      e.cnt = cnt;
      e.ovf = dropped;
      e.is_last = 1'b0;
      pending = {pending, e};
    endfunction

    function void merge_lists();
      int i;
      int j;
      int start_size;
      logic [CNT_W:0] sum;
      i = 0;
      j = 0;
      start_size = pending.size();
      merges++;
      while (i < keys_a.size() && j < keys_b.size()) begin
        if (keys_a[i] < keys_b[j]) begin
          push_entry(keys_a[i], cnts_a[i]);
          i++;
        end else if (keys_a[i] > keys_b[j]) begin
          push_entry(keys_b[j], cnts_b[j]);
          j++;
        end else begin
          sum = {1'b0, cnts_a[i]} + {1'b0, cnts_b[j]};
          if (sum[CNT_W]) begin
            saturated++;
            push_entry(keys_a[i], '1);
          end else begin
            push_entry(keys_a[i], sum[CNT_W-1:0]);
          end
          i++;
          j++;
        end
      end
      for (; i < keys_a.size(); i++) push_entry(keys_a[i], cnts_a[i]);
      for (; j < keys_b.size(); j++) push_entry(keys_b[j], cnts_b[j]);
      if (pending.size() > start_size) begin
        pending[pending.size() - 1].is_last = 1'b1;
      end
      keys_a.delete();
      keys_b.delete();
      cnts_a.delete();
      cnts_b.delete();
      dropped = 1'b0;
    endfunction

    function void note_command(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                               logic [CNT_W-1:0] cnt);
      case (mode)
        MODE_LOAD_A: begin
          if (keys_a.size() >= depth) begin
            dropped = 1'b1;
            dropped_loads++;
          end else begin
            keys_a = {keys_a, key};
            cnts_a = {cnts_a, cnt};
          end
        end
        MODE_LOAD_B: begin
          if (keys_b.size() >= depth) begin
            dropped = 1'b1;
            dropped_loads++;
          end else begin
            keys_b = {keys_b, key};
            cnts_b = {cnts_b, cnt};
          end
        end
        MODE_MERGE: begin
          merge_lists();
        end
        default: begin
        end
      endcase
    endfunction

    function void check_entry(merged_entry_t got);
      merged_entry_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: src=%h dst=%h count=%h ovf=%b last=%b",
                   got.src, got.dst, got.cnt, got.ovf, got.is_last);
      end else begin
        want = pending.pop_front();
        checked++;
        if (got.src !== want.src || got.dst !== want.dst || got.cnt !== want.cnt ||
            got.ovf !== want.ovf || got.is_last !== want.is_last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected src=%h dst=%h count=%h ovf=%b last=%b",
                     want.src, want.dst, want.cnt, want.ovf, want.is_last);
            $display("          got      src=%h dst=%h count=%h ovf=%b last=%b",
                     got.src, got.dst, got.cnt, got.ovf, got.is_last);
          end
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [MODE_W-1:0]   in_mode;
  logic [VERTEX_W-1:0] in_src_vertex;
  logic [VERTEX_W-1:0] in_dst_vertex;
  logic [CNT_W-1:0]    in_count;
  logic                out_valid;
  logic [VERTEX_W-1:0] out_src;
  logic [VERTEX_W-1:0] out_dst;
  logic [CNT_W-1:0]    out_count;
  logic                out_overflow;
  logic                out_last;

  pair_count_board board = new(DEPTH);
  int unsigned     items_sent;
  int unsigned     stall_cycles;
  bit              idle_on;

  sorted_pair_count_merge_top #(.LIST_DEPTH(DEPTH)) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_src_vertex(in_src_vertex),
    .in_dst_vertex(in_dst_vertex),
    .in_count     (in_count),
    .out_valid    (out_valid),
    .out_src      (out_src),
    .out_dst      (out_dst),
    .out_count    (out_count),
    .out_overflow (out_overflow),
    .out_last     (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_entry('{out_src, out_dst, out_count, out_overflow, out_last});
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", board.pending.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                           input logic [CNT_W-1:0] cnt);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_mode = mode;
    in_src_vertex = key[KEY_W-1:VERTEX_W];
    in_dst_vertex = key[VERTEX_W-1:0];
    in_count = cnt;
    do @(posedge clk); while (busy);
    board.note_command(mode, key, cnt);
    if (mode != MODE_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 3))
      0: return '1 - $urandom_range(0, 3);
      1: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_base();
    case ($urandom_range(0, 3))
      0: return {32'h0, 32'h0} + $urandom_range(0, 20);
      1: return '1 - $urandom_range(0, 40);
      2: return {$urandom, 32'hFFFFFFF0};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic run_sequence();
    int na;
    int nb;
    int ka;
    int kb;
    logic [KEY_W-1:0] key_a;
    logic [KEY_W-1:0] key_b;
    na = ($urandom_range(0, 7) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 3)
                                     : $urandom_range(0, 8);
    nb = ($urandom_range(0, 7) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 3)
                                     : $urandom_range(0, 8);
    key_a = pick_base();
    key_b = ($urandom_range(0, 3) == 0) ? pick_base() : key_a + $urandom_range(0, 2);
    ka = 0;
    kb = 0;
    while (ka < na || kb < nb) begin
      if (kb >= nb || (ka < na && $urandom_range(0, 1) == 0)) begin
        send_item(MODE_LOAD_A, key_a, pick_count());
        key_a = key_a + $urandom_range(1, 3);
        ka++;
      end else begin
        send_item(MODE_LOAD_B, key_b, pick_count());
        key_b = key_b + $urandom_range(1, 3);
        kb++;
      end
    end
    if ($urandom_range(0, 5) == 0) wait_drained();
    send_item(MODE_MERGE, {$urandom, $urandom}, $urandom);
  endtask

  initial begin
    int n;
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_LOAD_A;
    in_src_vertex = '0;
    in_dst_vertex = '0;
    in_count = '0;
    items_sent = 0;
    idle_on = 1'b1;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_item(MODE_LOAD_A, {32'h0, 32'h0}, 32'h0);
    send_item(MODE_LOAD_A, {32'h0, 32'h1}, 32'h7);
    send_item(MODE_LOAD_A, {32'hFFFFFFFF, 32'hFFFFFFFF}, 32'hFFFFFFFF);
    send_item(MODE_LOAD_B, {32'h0, 32'h1}, 32'h9);
    send_item(MODE_LOAD_B, {32'h80000000, 32'h0}, 32'h5);
    send_item(MODE_LOAD_B, {32'hFFFFFFFF, 32'hFFFFFFFF}, 32'h1);
    send_item(MODE_UNUSED, {$urandom, $urandom}, $urandom);
    send_item(MODE_MERGE, '0, '0);
    wait_drained();
    send_item(MODE_MERGE, '1, '1);
    send_item(MODE_LOAD_B, {32'h5, 32'h5}, 32'h3);
    send_item(MODE_LOAD_B, {32'hAAAAAAAA, 32'h55555555}, 32'h55555555);
    send_item(MODE_MERGE, '0, '0);
    send_item(MODE_LOAD_A, {32'h9, 32'h0}, 32'h1);
    send_item(MODE_LOAD_A, {32'h2, 32'h0}, 32'h2);
    send_item(MODE_LOAD_B, {32'h5, 32'h0}, 32'h3);
    send_item(MODE_LOAD_B, {32'h1, 32'h0}, 32'h4);
    send_item(MODE_MERGE, '0, '0);
    send_item(MODE_LOAD_A, {32'h55555555, 32'hAAAAAAAA}, 32'hAAAAAAAA);
    send_item(MODE_MERGE, '0, '0);
    send_item(MODE_LOAD_A, {32'h7, 32'h7}, 32'hFFFFFFFE);
    send_item(MODE_LOAD_B, {32'h7, 32'h7}, 32'h1);
    send_item(MODE_MERGE, '0, '0);

    while (items_sent < TARGET_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) send_item(MODE_W'($urandom_range(0, 3)), {$urandom, $urandom},
                             pick_count());
      end else begin
        run_sequence();
      end
    end
    send_item(MODE_MERGE, '0, '0);
    start = 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d commands in %0d merges, %0d loads dropped on full lists,",
             items_sent, board.merges, board.dropped_loads);
    $display("checked %0d merged entries, %0d of them saturated sums",
             board.checked, board.saturated);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results never seen", board.mismatches,
               board.pending.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
